/* design/nearest_point_sphere_distance_macros.svh */
// assertion macros for the nearest point sphere distance block
// no dependencies; SYNTH removes the checks
`ifndef NEAREST_POINT_SPHERE_DISTANCE_MACROS_SVH
`define NEAREST_POINT_SPHERE_DISTANCE_MACROS_SVH
`ifndef SYNTH
`define NPSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define NPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define NPSD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define NPSD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* design/npsd_pkg.sv */
// shared constants, types and tables for the nearest point sphere distance block
// no dependencies
`default_nettype none
package npsd_pkg;
    localparam int MAX_POINTS = 1024;
    localparam int IDX_W = 10;
    localparam int CNT_W = 11;
    localparam int STEPS = 28;
    localparam int STEP_W = 5;
    localparam int W = 36;
    localparam logic signed [W-1:0] Q_ONE = 36'sd1073741824;
    localparam logic signed [W-1:0] PI_Q = 36'sd843314857;
    localparam logic signed [W-1:0] HALF_PI_Q = 36'sd421657428;
    localparam logic signed [W-1:0] TWO_PI_Q = 36'sd1686629713;
    localparam logic signed [W-1:0] GAIN_Q = 36'sd652032874;

    function automatic logic signed [W-1:0] step_angle(input logic [STEP_W-1:0] i);
        logic signed [W-1:0] r;
        begin
            case (i)
                5'd0: r = 36'sd210828714;
                5'd1: r = 36'sd124459457;
                5'd2: r = 36'sd65760959;
                5'd3: r = 36'sd33381290;
                5'd4: r = 36'sd16755422;
                5'd5: r = 36'sd8385879;
                5'd6: r = 36'sd4193963;
                5'd7: r = 36'sd2097109;
                5'd8: r = 36'sd1048571;
                5'd9: r = 36'sd524287;
                default: r = (36'sd1 <<< (28 - i));
            endcase
            return r;
        end
    endfunction

    // cordic command and status
    typedef struct packed {
        logic start;
        logic vector_mode;
        logic signed [W-1:0] a;
        logic signed [W-1:0] b;
    } cordic_cmd_t;

    typedef struct packed {
        logic done;
        logic signed [W-1:0] c;
        logic signed [W-1:0] s;
        logic signed [W-1:0] z;
    } cordic_rsp_t;
endpackage
`default_nettype wire

/* design/npsd_cordic.sv */
// shared cordic unit: rotation gives cos and sin, vectoring gives atan2
// depends on npsd_pkg; rotation first reduces and folds the angle, then one step per cycle
`default_nettype none
`include "nearest_point_sphere_distance_macros.svh"
module npsd_cordic (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire npsd_pkg::cordic_cmd_t cmd,
    output npsd_pkg::cordic_rsp_t rsp
);
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RED  = 5'b00010,
        S_FOLD = 5'b00100,
        S_ITER = 5'b01000,
        S_DONE = 5'b10000
    } cst_t;

    cst_t state_reg, state_next;
    logic signed [npsd_pkg::W-1:0] x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [npsd_pkg::STEP_W-1:0] i_reg, i_next;
    logic vec_reg, vec_next, neg_reg, neg_next, zero_reg, zero_next;
    logic [2:0] red_reg, red_next;
    logic signed [npsd_pkg::W-1:0] dx, dy, ang, xc, yc;
    logic dir;

    assign dx = y_reg >>> i_reg;
    assign dy = x_reg >>> i_reg;
    assign ang = npsd_pkg::step_angle(i_reg);
    assign dir = vec_reg ? (y_reg > 0) : (z_reg >= 0);

    always_comb
    begin
        state_next = state_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        i_next = i_reg;
        vec_next = vec_reg;
        neg_next = neg_reg;
        zero_next = zero_reg;
        red_next = red_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.start)
                begin
                    vec_next = cmd.vector_mode;
                    neg_next = 1'b0;
                    i_next = '0;
                    if (cmd.vector_mode)
                    begin
                        zero_next = (cmd.a == 0) && (cmd.b == 0);
                        if (cmd.b < 0)
                        begin
                            x_next = cmd.a;
                            y_next = -cmd.b;
                            z_next = npsd_pkg::HALF_PI_Q;
                        end
                        else
                        begin
                            x_next = cmd.b;
                            y_next = cmd.a;
                            z_next = '0;
                        end
                        state_next = S_ITER;
                    end
                    else
                    begin
                        zero_next = 1'b0;
                        x_next = npsd_pkg::GAIN_Q;
                        y_next = '0;
                        z_next = cmd.a;
                        red_next = 3'd0;
                        state_next = S_RED;
                    end
                end
            end
            S_RED:
            begin
                // c-style remainder on 2*pi, then wrap to (-pi, pi]; |a| < 2^33 needs at most 6 passes
                if (z_reg >= npsd_pkg::TWO_PI_Q)
                    z_next = z_reg - npsd_pkg::TWO_PI_Q;
                else if (z_reg <= -npsd_pkg::TWO_PI_Q)
                    z_next = z_reg + npsd_pkg::TWO_PI_Q;
                else
                begin
                    if (z_reg > npsd_pkg::PI_Q)
                        z_next = z_reg - npsd_pkg::TWO_PI_Q;
                    else if (z_reg <= -npsd_pkg::PI_Q)
                        z_next = z_reg + npsd_pkg::TWO_PI_Q;
                    state_next = S_FOLD;
                end
                red_next = red_reg + 3'd1;
            end
            S_FOLD:
            begin
                if (z_reg > npsd_pkg::HALF_PI_Q)
                begin
                    z_next = npsd_pkg::PI_Q - z_reg;
                    neg_next = 1'b1;
                end
                else if (z_reg < -npsd_pkg::HALF_PI_Q)
                begin
                    z_next = -npsd_pkg::PI_Q - z_reg;
                    neg_next = 1'b1;
                end
                state_next = S_ITER;
            end
            S_ITER:
            begin
                if (dir)
                begin
                    x_next = vec_reg ? x_reg + dx : x_reg - dx;
                    y_next = vec_reg ? y_reg - dy : y_reg + dy;
                    z_next = vec_reg ? z_reg + ang : z_reg - ang;
                end
                else
                begin
                    x_next = vec_reg ? x_reg - dx : x_reg + dx;
                    y_next = vec_reg ? y_reg + dy : y_reg - dy;
                    z_next = vec_reg ? z_reg - ang : z_reg + ang;
                end
                i_next = i_reg + 1'b1;
                if (i_reg == npsd_pkg::STEP_W'(npsd_pkg::STEPS - 1))
                    state_next = S_DONE;
            end
            S_DONE:
                state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            i_reg <= '0;
            red_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg <= i_next;
            red_reg <= red_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        vec_reg <= vec_next;
        neg_reg <= neg_next;
        zero_reg <= zero_next;
    end

    assign xc = (x_reg > npsd_pkg::Q_ONE) ? npsd_pkg::Q_ONE :
                (x_reg < -npsd_pkg::Q_ONE) ? -npsd_pkg::Q_ONE : x_reg;
    assign yc = (y_reg > npsd_pkg::Q_ONE) ? npsd_pkg::Q_ONE :
                (y_reg < -npsd_pkg::Q_ONE) ? -npsd_pkg::Q_ONE : y_reg;

    always_comb
    begin
        rsp.done = (state_reg == S_DONE);
        rsp.c = neg_reg ? -xc : xc;
        rsp.s = yc;
        if (zero_reg || z_reg < 0)
            rsp.z = '0;
        else if (z_reg > npsd_pkg::PI_Q)
            rsp.z = npsd_pkg::PI_Q;
        else
            rsp.z = z_reg;
    end

    `NPSD_ASSERT_NEXT(a_start_leaves_idle, clk, rst_n, state_reg == S_IDLE && cmd.start, state_reg != S_IDLE)
    `NPSD_ASSERT_IMPL(a_red_bounded, clk, rst_n, state_reg == S_RED, red_reg < 3'd7)
    `NPSD_ASSERT_NEXT(a_done_one_cycle, clk, rst_n, state_reg == S_DONE, state_reg == S_IDLE)
endmodule
`default_nettype wire

/* design/nearest_point_sphere_distance.sv */
// top level of the nearest point sphere distance block: sequencer, point tables, multiplier
// depends on npsd_pkg, npsd_cordic and the assertion macro header
//
// A load request (mode 0) computes cos and sin of dec with the shared cordic
// and stores ra, cos, sin at its slot; the input is ready again once the slot
// is written. A query request (mode 1) first computes its own cos and sin,
// then for each of points_in_use points reads the tables, runs one rotation
// cordic pass on the ra difference, nine registered 36x36 products, a
// bit-pair square root, one vectoring cordic pass and the min compare; the
// result then enters the output register. Work is serialised on the shared
// cordic and the single multiplier. The input is stalled (in_stall high) while
// a request is in work, including while a finished query waits for the output
// register to free up. The tables have no reset; slots must be loaded before
// queried.
`default_nettype none
`include "nearest_point_sphere_distance_macros.svh"
module nearest_point_sphere_distance (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cfg_we,
    input  wire logic [10:0] cfg_wdata,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire logic mode,
    input  wire logic [9:0] slot,
    input  wire logic signed [29:0] dec,
    input  wire logic signed [31:0] ra,
    input  wire logic frame_end,
    output logic out_valid,
    input  wire logic out_stall,
    output logic [29:0] min_distance,
    output logic [9:0] nearest_index,
    output logic no_points,
    output logic frame_end_res
);
    localparam int W = npsd_pkg::W;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_SC   = 12'b000000000010,
        S_RD   = 12'b000000000100,
        S_RDW  = 12'b000000001000,
        S_ROT  = 12'b000000010000,
        S_MUL  = 12'b000000100000,
        S_SQ   = 12'b000001000000,
        S_VEC  = 12'b000010000000,
        S_CMP  = 12'b000100000000,
        S_OUT  = 12'b001000000000,
        S_NEXT = 12'b010000000000,
        S_WSC  = 12'b100000000000
    } st_t;

    st_t state_reg, state_next;
    logic [10:0] piu_reg;
    logic mode_reg;
    logic [9:0] slot_reg;
    logic signed [29:0] dec_reg;
    logic signed [31:0] ra_reg;
    logic fe_reg;
    logic signed [W-1:0] pc_reg, ps_reg;
    logic [npsd_pkg::CNT_W-1:0] n_reg, j_reg;
    logic [npsd_pkg::IDX_W-1:0] rd_addr;
    logic signed [31:0] ra_mem [0:npsd_pkg::MAX_POINTS-1];
    logic signed [31:0] cos_mem [0:npsd_pkg::MAX_POINTS-1];
    logic signed [31:0] sin_mem [0:npsd_pkg::MAX_POINTS-1];
    logic signed [31:0] tra_reg, tc_reg, ts_reg;
    logic signed [W-1:0] cd_reg, sd_reg;
    logic [3:0] mstep_reg;
    logic signed [W-1:0] t1_reg, t2_reg, y1_reg, y2_reg, x_reg;
    logic [63:0] sq_reg, rem_reg, root_reg, bit_reg;
    logic [5:0] qstep_reg;
    logic signed [W-1:0] best_reg;
    logic [npsd_pkg::IDX_W-1:0] bidx_reg;
    logic out_valid_reg, out_np_reg, out_fe_reg;
    logic [29:0] out_d_reg;
    logic [9:0] out_i_reg;
    npsd_pkg::cordic_cmd_t cmd;
    npsd_pkg::cordic_rsp_t rsp;
    logic signed [W-1:0] ma, mb;
    logic signed [2*W-1:0] prod;
    logic signed [W-1:0] pq;
    logic [63:0] trial;
    logic in_acc;

    npsd_cordic u_cordic (.clk(clk), .rst_n(rst_n), .cmd(cmd), .rsp(rsp));

    assign in_acc = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign rd_addr = j_reg[npsd_pkg::IDX_W-1:0];

    // multiplier operand schedule: y1, ps*tc, pc*tc, pc*ts, ps*ts, then the cd products and the squares of y1 and y2
    always_comb
    begin
        case (mstep_reg)
            4'd0: begin ma = W'(tc_reg); mb = sd_reg; end
            4'd1: begin ma = ps_reg; mb = W'(tc_reg); end
            4'd2: begin ma = pc_reg; mb = W'(tc_reg); end
            4'd3: begin ma = pc_reg; mb = W'(ts_reg); end
            4'd4: begin ma = ps_reg; mb = W'(ts_reg); end
            4'd5: begin ma = t1_reg; mb = cd_reg; end
            4'd6: begin ma = t2_reg; mb = cd_reg; end
            4'd7: begin ma = y1_reg; mb = y1_reg; end
            default: begin ma = y2_reg; mb = y2_reg; end
        endcase
    end
    assign prod = ma * mb;
    assign pq = W'(prod >>> 30);
    assign trial = root_reg + bit_reg;

    always_comb
    begin
        cmd.start = 1'b0;
        cmd.vector_mode = 1'b0;
        cmd.a = '0;
        cmd.b = '0;
        case (state_reg)
            S_SC:
            begin
                cmd.start = 1'b1;
                cmd.a = W'(dec_reg);
            end
            S_ROT:
            begin
                cmd.start = 1'b1;
                cmd.a = W'(ra_reg) - W'(tra_reg);
            end
            S_VEC:
            begin
                cmd.start = 1'b1;
                cmd.vector_mode = 1'b1;
                cmd.a = root_reg[W-1:0];
                cmd.b = x_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WSC && rsp.done && !mode_reg)
        begin
            ra_mem[slot_reg] <= ra_reg;
            cos_mem[slot_reg] <= rsp.c[31:0];
            sin_mem[slot_reg] <= rsp.s[31:0];
        end
        tra_reg <= ra_mem[rd_addr];
        tc_reg <= cos_mem[rd_addr];
        ts_reg <= sin_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_acc) state_next = S_SC;
            S_SC: state_next = S_WSC;
            S_WSC:
                if (rsp.done)
                    state_next = !mode_reg ? S_IDLE : (n_reg == 0 ? S_OUT : S_RD);
            S_RD: state_next = S_RDW;
            S_RDW: state_next = S_ROT;
            S_ROT: state_next = S_NEXT;
            S_NEXT: if (rsp.done) state_next = S_MUL;
            S_MUL: if (mstep_reg == 4'd8) state_next = S_SQ;
            S_SQ: if (qstep_reg == 6'd32) state_next = S_VEC;
            S_VEC: state_next = S_CMP;
            S_CMP:
                if (rsp.done)
                    state_next = (j_reg + 1'b1 == n_reg) ? S_OUT : S_RD;
            S_OUT: if (!out_valid_reg || !out_stall) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            piu_reg <= '0;
            out_valid_reg <= 1'b0;
            j_reg <= '0;
            mstep_reg <= '0;
            qstep_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                piu_reg <= cfg_wdata;
            // a new result replaces the old one in the same cycle it leaves
            if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (state_reg == S_WSC)
                j_reg <= '0;
            if (state_reg == S_CMP && rsp.done)
                j_reg <= j_reg + 1'b1;
            if (state_reg == S_NEXT)
                mstep_reg <= '0;
            else if (state_reg == S_MUL)
                mstep_reg <= mstep_reg + 4'd1;
            if (state_reg == S_MUL)
                qstep_reg <= '0;
            else if (state_reg == S_SQ)
                qstep_reg <= qstep_reg + 6'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            mode_reg <= mode;
            slot_reg <= slot;
            dec_reg <= dec;
            ra_reg <= ra;
            fe_reg <= frame_end;
            n_reg <= (piu_reg > 11'(npsd_pkg::MAX_POINTS)) ?
                     11'(npsd_pkg::MAX_POINTS) : piu_reg;
        end
        if (state_reg == S_WSC && rsp.done)
        begin
            pc_reg <= rsp.c;
            ps_reg <= rsp.s;
        end
        if (state_reg == S_NEXT && rsp.done)
        begin
            cd_reg <= rsp.c;
            sd_reg <= rsp.s;
        end
        if (state_reg == S_MUL)
        begin
            case (mstep_reg)
                4'd0: y1_reg <= pq;
                4'd1: t1_reg <= pq;
                4'd2: t2_reg <= pq;
                4'd3: y2_reg <= pq;
                4'd4: x_reg <= pq;
                4'd5: y2_reg <= y2_reg - pq;
                4'd6: x_reg <= x_reg + pq;
                4'd7: sq_reg <= 64'(prod);
                default: sq_reg <= sq_reg + 64'(prod);
            endcase
        end
        if (state_reg == S_MUL && mstep_reg == 4'd8)
        begin
            rem_reg <= sq_reg + 64'(prod);
            root_reg <= '0;
            bit_reg <= 64'd1 << 62;
        end
        else if (state_reg == S_SQ && qstep_reg != 6'd32)
        begin
            if (rem_reg >= trial)
            begin
                rem_reg <= rem_reg - trial;
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
                root_reg <= root_reg >> 1;
            bit_reg <= bit_reg >> 2;
        end
        if (state_reg == S_CMP && rsp.done && (j_reg == 0 || rsp.z < best_reg))
        begin
            best_reg <= rsp.z;
            bidx_reg <= rd_addr;
        end
        if (state_reg == S_OUT && (!out_valid_reg || !out_stall))
        begin
            out_np_reg <= (n_reg == 0);
            out_d_reg <= (n_reg == 0) ? 30'd0 : best_reg[29:0];
            out_i_reg <= (n_reg == 0) ? 10'd0 : bidx_reg;
            out_fe_reg <= fe_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign min_distance = out_d_reg;
    assign nearest_index = out_i_reg;
    assign no_points = out_np_reg;
    assign frame_end_res = out_fe_reg;

    `NPSD_ASSERT_IMPL(a_busy_stalls, clk, rst_n, state_reg != S_IDLE, in_stall)
    `NPSD_ASSERT_NEXT(a_out_holds, clk, rst_n, out_valid_reg && out_stall, out_valid_reg && $stable(out_d_reg))
    `NPSD_ASSERT_IMPL(a_scan_bound, clk, rst_n, state_reg == S_RD, j_reg < n_reg)
endmodule
`default_nettype wire
